[src/scaled_column_texel_colorkey_defines.svh]
// Assertion macros shared by the textured column block.
`ifndef SCALED_COLUMN_TEXEL_COLORKEY_DEFINES_SVH
`define SCALED_COLUMN_TEXEL_COLORKEY_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SCTC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sctc: check failed");
`define SCTC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sctc: check failed");
`else
`define SCTC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define SCTC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[src/sctc_pkg.sv]
// Shared types, constants and color key function of the textured column block.
package sctc_pkg;

  localparam int SCREEN_ROWS_DEF  = 512;
  localparam int SCREEN_COLS_DEF  = 1024;
  localparam int TEX_ROWS_MAX_DEF = 64;
  localparam int TILE_UNITS_DEF   = 64;

  localparam logic [1:0] REG_PROJ_DIST   = 2'd0;
  localparam logic [1:0] REG_PITCH       = 2'd1;
  localparam logic [1:0] REG_TEX_HEIGHT  = 2'd2;
  localparam logic [1:0] REG_TEX_PRESENT = 2'd3;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_SHADE = 1'b1;

  localparam logic [23:0] PROJ_DIST_RST  = 24'd227023;
  localparam logic [6:0]  TEX_HEIGHT_RST = 7'd64;
  localparam logic [23:0] MIN_DIST_RAW   = 24'd1280;

  typedef struct packed {
    logic        func;
    logic [5:0]  texel_row;
    logic [31:0] texel_color;
    logic [9:0]  scr_col;
    logic [8:0]  row_y;
    logic        draw;
  } item_t;

  typedef struct packed {
    logic        write_pixel;
    logic [9:0]  pixel_x;
    logic [8:0]  pixel_y;
    logic [31:0] pixel_color;
  } result_t;

  function automatic logic keyed_out(input logic [31:0] c);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = c[23:16];
    g = c[15:8];
    b = c[7:0];
    keyed_out = (r < 8'd20 && g < 8'd20 && b < 8'd20) ||
                (r > 8'd240 && g > 8'd240 && b > 8'd240) ||
                (r >= 8'd250 && g <= 8'd5 && b <= 8'd5);
  endfunction

endpackage

[src/sctc_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module sctc_div_pipe #(
  parameter int NW  = 8,
  parameter int DW  = 8,
  parameter int QW  = 4,
  parameter int SBW = 1
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_valid,
  input  logic [NW-1:0]  in_num,
  input  logic [DW-1:0]  in_den,
  input  logic [SBW-1:0] in_side,
  output logic           out_valid,
  output logic [QW-1:0]  out_quot,
  output logic           out_ovf,
  output logic [SBW-1:0] out_side
);

  localparam int EW = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [NW-1:0]  w_rem  [QW+1];
  logic [DW-1:0]  w_den  [QW+1];
  logic [QW-1:0]  w_quot [QW+1];
  logic           w_ovf  [QW+1];
  logic           w_v    [QW+1];
  logic [SBW-1:0] w_side [QW+1];

  assign w_rem[0]  = in_num;
  assign w_den[0]  = in_den;
  assign w_quot[0] = '0;
  assign w_ovf[0]  = EW'(in_num) >= (EW'(in_den) << QW);
  assign w_v[0]    = in_valid;
  assign w_side[0] = in_side;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [EW-1:0]  trial;
    logic           ge;
    logic [NW-1:0]  rem_r;
    logic [DW-1:0]  den_r;
    logic [QW-1:0]  quot_r;
    logic           ovf_r;
    logic           v_r;
    logic [SBW-1:0] side_r;

    assign trial = EW'(w_den[k]) << B;
    assign ge    = EW'(w_rem[k]) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en) begin
        v_r <= w_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r  <= ge ? NW'(EW'(w_rem[k]) - trial) : w_rem[k];
        den_r  <= w_den[k];
        quot_r <= w_quot[k] | (QW'(ge) << B);
        ovf_r  <= w_ovf[k];
        side_r <= w_side[k];
      end
    end

    assign w_rem[k+1]  = rem_r;
    assign w_den[k+1]  = den_r;
    assign w_quot[k+1] = quot_r;
    assign w_ovf[k+1]  = ovf_r;
    assign w_v[k+1]    = v_r;
    assign w_side[k+1] = side_r;
  end

  assign out_valid = w_v[QW];
  assign out_quot  = w_quot[QW];
  assign out_ovf   = w_ovf[QW];
  assign out_side  = w_side[QW];

endmodule

[src/sctc_texel_store.sv]
// Texture column memory: load writes, shade reads, color key on the read word.
module sctc_texel_store #(
  parameter int TEX_ROWS_MAX = 64,
  parameter int AW           = 6
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  sctc_pkg::item_t   in_item,
  input  logic [AW-1:0]     rd_addr,
  output logic              out_valid,
  output sctc_pkg::result_t out_res
);
  import sctc_pkg::*;

  logic [31:0]   mem [TEX_ROWS_MAX];
  logic [31:0]   rd_data_r;
  logic          m_v_r;
  item_t         m_item_r;
  logic [10:0]   row_w;
  logic          wr_ok;
  logic [AW-1:0] wr_addr;
  logic          draw;

  assign row_w   = 11'(in_item.texel_row);
  assign wr_ok   = row_w < 11'(TEX_ROWS_MAX);
  assign wr_addr = row_w[AW-1:0];

  // loads and shades pass this stage in order, so a read sees every earlier load
  always_ff @(posedge clk) begin
    if (en && in_valid && in_item.func == FUNC_LOAD && wr_ok) begin
      mem[wr_addr] <= in_item.texel_color;
    end
    if (en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_v_r <= 1'b0;
    end else if (en) begin
      m_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_item_r <= in_item;
    end
  end

  assign draw = m_item_r.draw && !keyed_out(rd_data_r);

  assign out_valid           = m_v_r;
  assign out_res.write_pixel = draw;
  assign out_res.pixel_x     = draw ? m_item_r.scr_col : '0;
  assign out_res.pixel_y     = draw ? m_item_r.row_y : '0;
  assign out_res.pixel_color = draw ? rd_data_r : '0;

endmodule

[src/scaled_column_texel_colorkey.sv]
// Top level of the textured door column shader with color key.
// Takes one item per clock (texel load or row shade) while in_stall is low and returns
// one result item per item, in order. Each item passes, in order, the height multiply,
// the projected height divider, span placement, span clipping and the texel row
// multiply, the texel row divider, the texture memory read and the output register.
// Loads write the texture memory (one write and one read port) at the same stage where
// shades read it, so item order is kept without forwarding. A skid register behind the
// output lets one more item in while a result waits; in_stall rises once that skid
// register is full.
module scaled_column_texel_colorkey #(
  parameter int SCREEN_ROWS  = sctc_pkg::SCREEN_ROWS_DEF,
  parameter int SCREEN_COLS  = sctc_pkg::SCREEN_COLS_DEF,
  parameter int TEX_ROWS_MAX = sctc_pkg::TEX_ROWS_MAX_DEF,
  parameter int TILE_UNITS   = sctc_pkg::TILE_UNITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic [5:0]  in_texel_row,
  input  logic [31:0] in_texel_color,
  input  logic [9:0]  in_scr_col,
  input  logic [8:0]  in_row_y,
  input  logic [23:0] in_distance,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_write_pixel,
  output logic [9:0]  out_pixel_x,
  output logic [8:0]  out_pixel_y,
  output logic [31:0] out_pixel_color,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sctc_pkg::*;
  `include "scaled_column_texel_colorkey_defines.svh"

  localparam int RW  = $clog2(SCREEN_ROWS) + 1;
  localparam int SW  = ((RW > 12) ? RW : 12) + 2;
  localparam int MW  = $clog2(TILE_UNITS * 14 + 1);
  localparam int NW1 = 24 + MW;
  localparam int DW1 = 28;
  localparam int NW2 = RW + 7;
  localparam int AW  = (TEX_ROWS_MAX > 1) ? $clog2(TEX_ROWS_MAX) : 1;
  localparam int IB  = $bits(item_t);

  // configuration registers
  logic [23:0] proj_dist_r;
  logic [10:0] pitch_r;
  logic [6:0]  tex_height_r;
  logic        tex_present_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      proj_dist_r   <= PROJ_DIST_RST;
      pitch_r       <= '0;
      tex_height_r  <= TEX_HEIGHT_RST;
      tex_present_r <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        REG_PROJ_DIST:   proj_dist_r   <= pwdata[23:0];
        REG_PITCH:       pitch_r       <= pwdata[10:0];
        REG_TEX_HEIGHT:  tex_height_r  <= pwdata[6:0];
        REG_TEX_PRESENT: tex_present_r <= pwdata[0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_PROJ_DIST:   prdata = 32'(proj_dist_r);
      REG_PITCH:       prdata = 32'(pitch_r);
      REG_TEX_HEIGHT:  prdata = 32'(tex_height_r);
      REG_TEX_PRESENT: prdata = 32'(tex_present_r);
      default:         prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // pipeline control
  logic    en;
  logic    skid_v_r;
  result_t skid_res_r;
  logic    out_v_r;
  result_t out_res_r;
  logic    st_v;
  result_t st_res;

  assign en       = !skid_v_r;
  assign in_stall = skid_v_r;

  // stage A: height numerator and denominator
  logic           a_v_r;
  logic [NW1-1:0] a_num_r;
  logic [DW1-1:0] a_den_r;
  item_t          a_item_r;
  item_t          in_item;

  assign in_item.func        = in_func;
  assign in_item.texel_row   = in_texel_row;
  assign in_item.texel_color = in_texel_color;
  assign in_item.scr_col     = in_scr_col;
  assign in_item.row_y       = in_row_y;
  assign in_item.draw        = in_func == FUNC_SHADE && tex_present_r &&
                               in_distance >= MIN_DIST_RAW &&
                               32'(in_scr_col) < SCREEN_COLS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en) begin
      a_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_num_r  <= NW1'(proj_dist_r) * NW1'(TILE_UNITS * 14);
      a_den_r  <= (DW1'(in_distance) << 3) + (DW1'(in_distance) << 1);
      a_item_r <= in_item;
    end
  end

  // projected height divider
  logic          d1_v;
  logic [RW-1:0] d1_q;
  logic          d1_ovf;
  logic [IB-1:0] d1_side;
  item_t         d1_item;

  sctc_div_pipe #(.NW(NW1), .DW(DW1), .QW(RW), .SBW(IB)) u_hdiv (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(a_v_r), .in_num(a_num_r), .in_den(a_den_r), .in_side(a_item_r),
    .out_valid(d1_v), .out_quot(d1_q), .out_ovf(d1_ovf), .out_side(d1_side)
  );

  assign d1_item = item_t'(d1_side);

  // stage B1: clamp height, place span
  logic                 b1_v_r;
  logic signed [SW-1:0] b1_top_r;
  logic signed [SW-1:0] b1_bot_r;
  item_t                b1_item_r;
  logic [RW-1:0]        h;
  logic signed [SW-1:0] top_w;

  always_comb begin
    if (d1_ovf || 32'(d1_q) > SCREEN_ROWS) begin
      h = RW'(SCREEN_ROWS);
    end else if (d1_q == '0) begin
      h = RW'(1);
    end else begin
      h = d1_q;
    end
    top_w = SW'(SCREEN_ROWS / 2) - SW'(h >> 1) + SW'($signed(pitch_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_v_r <= 1'b0;
    end else if (en) begin
      b1_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_top_r  <= top_w;
      b1_bot_r  <= top_w + SW'(h);
      b1_item_r <= d1_item;
    end
  end

  // stage B2: clip span to the screen, test the row
  logic                 b2_v_r;
  logic [RW-1:0]        b2_span_r;
  logic [RW-1:0]        b2_dy_r;
  item_t                b2_item_r;
  logic signed [SW-1:0] top_c;
  logic signed [SW-1:0] bot_c;
  logic signed [SW-1:0] y_s;
  logic signed [SW-1:0] span_w;
  logic signed [SW-1:0] dy_w;
  logic                 in_span;
  item_t                b2_item;

  always_comb begin
    top_c   = (b1_top_r < 0) ? '0 : b1_top_r;
    bot_c   = (b1_bot_r >= SW'(SCREEN_ROWS)) ? SW'(SCREEN_ROWS - 1) : b1_bot_r;
    y_s     = SW'($signed({1'b0, b1_item_r.row_y}));
    in_span = !(top_c > bot_c) && y_s >= top_c && y_s <= bot_c;
    span_w  = bot_c - top_c + SW'(1);
    dy_w    = y_s - top_c;
    b2_item = b1_item_r;
    b2_item.draw = b1_item_r.draw && in_span;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_v_r <= 1'b0;
    end else if (en) begin
      b2_v_r <= b1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_span_r <= span_w[RW-1:0];
      b2_dy_r   <= dy_w[RW-1:0];
      b2_item_r <= b2_item;
    end
  end

  // stage B3: scale row offset by texture height
  logic           b3_v_r;
  logic [NW2-1:0] b3_prod_r;
  logic [RW-1:0]  b3_span_r;
  item_t          b3_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_v_r <= 1'b0;
    end else if (en) begin
      b3_v_r <= b2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_prod_r <= NW2'(b2_dy_r) * NW2'(tex_height_r);
      b3_span_r <= b2_span_r;
      b3_item_r <= b2_item_r;
    end
  end

  // texel row divider
  logic          d2_v;
  logic [6:0]    d2_q;
  logic          d2_ovf;
  logic [IB-1:0] d2_side;
  item_t         d2_item;

  sctc_div_pipe #(.NW(NW2), .DW(RW), .QW(7), .SBW(IB)) u_tdiv (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(b3_v_r), .in_num(b3_prod_r), .in_den(b3_span_r), .in_side(b3_item_r),
    .out_valid(d2_v), .out_quot(d2_q), .out_ovf(d2_ovf), .out_side(d2_side)
  );

  assign d2_item = item_t'(d2_side);

  // clamp texel row to the rows in use and to the store depth
  logic [6:0]    idx7;
  logic [10:0]   idx_w;
  logic [AW-1:0] rd_addr;

  always_comb begin
    if (tex_height_r == '0) begin
      idx7 = '0;
    end else if (d2_ovf || d2_q >= tex_height_r) begin
      idx7 = tex_height_r - 7'd1;
    end else begin
      idx7 = d2_q;
    end
    idx_w = 11'(idx7);
    if (idx_w >= 11'(TEX_ROWS_MAX)) begin
      idx_w = 11'(TEX_ROWS_MAX - 1);
    end
  end

  assign rd_addr = idx_w[AW-1:0];

  sctc_texel_store #(.TEX_ROWS_MAX(TEX_ROWS_MAX), .AW(AW)) u_store (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(d2_v), .in_item(d2_item), .rd_addr(rd_addr),
    .out_valid(st_v), .out_res(st_res)
  );

  // output register with skid
  logic out_free;
  logic out_zero;

  assign out_free = !out_v_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (out_free) begin
        out_v_r   <= 1'b1;
        out_res_r <= skid_res_r;
        skid_v_r  <= 1'b0;
      end
    end else if (out_free) begin
      out_v_r   <= st_v;
      out_res_r <= st_res;
    end else if (st_v) begin
      skid_v_r   <= 1'b1;
      skid_res_r <= st_res;
    end
  end

  assign out_valid       = out_v_r;
  assign out_write_pixel = out_res_r.write_pixel;
  assign out_pixel_x     = out_res_r.pixel_x;
  assign out_pixel_y     = out_res_r.pixel_y;
  assign out_pixel_color = out_res_r.pixel_color;

  assign out_zero = out_res_r.pixel_color == '0 && out_res_r.pixel_x == '0 &&
                    out_res_r.pixel_y == '0;

  `SCTC_ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_v_r, out_v_r)
  `SCTC_ASSERT_NXT(a_skid_kept, clk, rst_n, skid_v_r && out_stall, skid_v_r)
  `SCTC_ASSERT_IMP(a_nowrite_zero, clk, rst_n, out_v_r && !out_res_r.write_pixel, out_zero)

endmodule
